/* sv/grc_pkg.sv */
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants and types of the granule reference counter.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int NUM_GRANULES = 1024;
    localparam int GIDX_W       = 10;
    localparam int COUNT_W      = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam int MAX_SPAN     = 16;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 21;
    localparam int GRAN_W = 13;
    localparam int STAT_W = 3;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_BYTES = 2'd1;
    localparam logic [1:0] REG_GRAN  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERO    = 3'd3;
    localparam logic [STAT_W-1:0] ST_SPAN    = 3'd4;

    // classified walk handed from front to back
    typedef struct packed {
        logic              action;
        logic              reject;
        logic [STAT_W-1:0] status;
        logic [GIDX_W-1:0] gs;
        logic [5:0]        count;     // granules to walk, up to 16
        logic [LEN_W-1:0]  cs;        // gs * granule size
    } walk_t;

endpackage

/* sv/grc_front.sv */
// ----------------------------------------------------------------------------
// grc_front
// Accepts requests, checks the region and divides by the granule size.
// ----------------------------------------------------------------------------
module grc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [grc_pkg::ADDR_W-1:0]    address,
    input  logic [grc_pkg::LEN_W-1:0]     length,
    input  logic [grc_pkg::ADDR_W-1:0]    region_base,
    input  logic [grc_pkg::LEN_W-1:0]     region_bytes,
    input  logic [grc_pkg::GRAN_W-1:0]    gran,
    output logic                          q_valid,
    input  logic                          q_ready,
    output grc_pkg::walk_t                q_data
);
    typedef enum logic [1:0] {F_IDLE, F_DIV, F_CLASS, F_DONE} fstate_t;

    fstate_t                     state_reg;
    logic [grc_pkg::LEN_W:0]     off_reg, end_reg;   // 22 bits
    logic [grc_pkg::LEN_W:0]     rem_a_reg, rem_b_reg;
    logic [grc_pkg::LEN_W:0]     q_a_reg, q_b_reg;
    logic [4:0]                  bit_reg;
    grc_pkg::walk_t              out_reg;

    logic [grc_pkg::GRAN_W-1:0]  g;
    logic [grc_pkg::ADDR_W:0]    diff;
    logic [grc_pkg::LEN_W:0]     end_w;
    logic                        outside, too_long;
    logic [grc_pkg::LEN_W+1:0]   g_w;
    logic [grc_pkg::LEN_W+1:0]   na, nb;
    logic                        qa_bit, qb_bit;
    logic [grc_pkg::LEN_W:0]     ta, tb, ge, span;
    logic [grc_pkg::LEN_W-1:0]   cs_w;
    logic                        span_bad;

    assign g        = (gran == '0) ? grc_pkg::GRAN_W'(1) : gran;
    assign diff     = {1'b0, address} - {1'b0, region_base};
    assign end_w    = diff[grc_pkg::LEN_W:0] + (grc_pkg::LEN_W+1)'(length);
    assign outside  = diff[grc_pkg::ADDR_W] ||
                      (diff[grc_pkg::ADDR_W-1:0] >= grc_pkg::ADDR_W'(region_bytes));
    assign too_long = end_w > (grc_pkg::LEN_W+1)'(region_bytes);

    // restoring division, one quotient bit of both operands per cycle
    always_comb begin
        g_w    = (grc_pkg::LEN_W+2)'(g);
        na     = {rem_a_reg, off_reg[bit_reg]};
        nb     = {rem_b_reg, end_reg[bit_reg]};
        qa_bit = (na >= g_w);
        qb_bit = (nb >= g_w);
        ta = qa_bit ? (grc_pkg::LEN_W+1)'(na - g_w) : (grc_pkg::LEN_W+1)'(na);
        tb = qb_bit ? (grc_pkg::LEN_W+1)'(nb - g_w) : (grc_pkg::LEN_W+1)'(nb);
        // classify the finished quotients: end rounded up
        ge       = q_b_reg + ((rem_b_reg != '0) ? 22'd1 : 22'd0);
        span     = ge - q_a_reg;
        cs_w     = grc_pkg::LEN_W'(q_a_reg * g);
        span_bad = (ge > q_a_reg) && ((span > 22'(grc_pkg::MAX_SPAN)) ||
                                      (ge > 22'(grc_pkg::NUM_GRANULES)));
    end

    assign in_ready = (state_reg == F_IDLE);
    assign q_valid  = (state_reg == F_DONE);
    assign q_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            unique case (state_reg)
                F_IDLE: if (in_valid) begin
                    out_reg.action <= action;
                    out_reg.reject <= outside || too_long;
                    out_reg.status <= outside  ? grc_pkg::ST_OUTSIDE :
                                      too_long ? grc_pkg::ST_SPAN : grc_pkg::ST_OK;
                    out_reg.gs     <= '0;
                    out_reg.count  <= '0;
                    out_reg.cs     <= '0;
                    off_reg   <= diff[grc_pkg::LEN_W:0];
                    end_reg   <= end_w;
                    rem_a_reg <= '0;
                    rem_b_reg <= '0;
                    q_a_reg   <= '0;
                    q_b_reg   <= '0;
                    bit_reg   <= 5'(grc_pkg::LEN_W);
                    state_reg <= (outside || too_long) ? F_DONE : F_DIV;
                end
                F_DIV: begin
                    rem_a_reg <= ta;
                    rem_b_reg <= tb;
                    q_a_reg   <= {q_a_reg[grc_pkg::LEN_W-1:0], qa_bit};
                    q_b_reg   <= {q_b_reg[grc_pkg::LEN_W-1:0], qb_bit};
                    if (bit_reg == '0) state_reg <= F_CLASS;
                    else               bit_reg <= bit_reg - 5'd1;
                end
                F_CLASS: begin
                    out_reg.gs <= q_a_reg[grc_pkg::GIDX_W-1:0];
                    out_reg.cs <= cs_w;
                    if (span_bad) begin
                        out_reg.reject <= 1'b1;
                        out_reg.status <= grc_pkg::ST_SPAN;
                        out_reg.count  <= '0;
                    end else begin
                        out_reg.count <= (ge > q_a_reg) ? span[5:0] : 6'd0;
                    end
                    state_reg <= F_DONE;
                end
                F_DONE: begin
                    if (q_ready) state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

/* sv/grc_queue.sv */
// ----------------------------------------------------------------------------
// grc_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module grc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  grc_pkg::walk_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output grc_pkg::walk_t rd_data
);
    grc_pkg::walk_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wp_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("queue count overflow");
    a_pop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_push_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full queue");
endmodule

/* sv/grc_back.sv */
// ----------------------------------------------------------------------------
// grc_back
// Walks the counters with read-modify-write and emits results.
// ----------------------------------------------------------------------------
module grc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  grc_pkg::walk_t                q_data,
    input  logic [grc_pkg::LEN_W-1:0]     region_bytes,
    input  logic [grc_pkg::GRAN_W-1:0]    gran,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);
    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_WAIT, B_MOD, B_OUT} bstate_t;

    bstate_t                      state_reg;
    logic [grc_pkg::COUNT_W-1:0]  cnt_mem [grc_pkg::NUM_GRANULES];
    logic [grc_pkg::COUNT_W-1:0]  rd_reg;
    logic [grc_pkg::GIDX_W-1:0]   idx_reg;
    logic [5:0]                   left_reg;
    logic [grc_pkg::LEN_W-1:0]    cs_reg;
    logic                         action_reg;
    logic                         final_reg;
    logic [grc_pkg::STAT_W-1:0]   st_reg;
    logic                         ov_reg;
    logic [grc_pkg::GIDX_W-1:0]   o_idx_reg;
    logic [grc_pkg::LEN_W-1:0]    o_cs_reg, o_ce_reg;
    logic [grc_pkg::STAT_W-1:0]   o_st_reg;
    logic                         o_kind_reg;
    logic                         o_last_reg;

    logic                         we;
    logic [grc_pkg::COUNT_W-1:0]  wdata;
    logic [grc_pkg::GIDX_W-1:0]   waddr;
    logic [grc_pkg::GRAN_W-1:0]   g;
    logic [grc_pkg::LEN_W:0]      ce_w;
    logic [grc_pkg::LEN_W-1:0]    ce_clip;
    logic                         out_load;

    assign g        = (gran == '0) ? grc_pkg::GRAN_W'(1) : gran;
    assign ce_w     = {1'b0, cs_reg} + 22'(g);
    assign ce_clip  = (ce_w > 22'(region_bytes)) ? region_bytes : ce_w[grc_pkg::LEN_W-1:0];
    assign q_ready  = (state_reg == B_IDLE);
    // load the output register only when no result is held or the held one is being taken
    assign out_load = (state_reg == B_OUT) && (!ov_reg || m_tready);

    assign m_tvalid = ov_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    // tdata: granule_index[9:0], clear_start[30:10], clear_end[51:31], status[54:52]
    assign m_tdata  = {1'b0, o_st_reg, o_ce_reg, o_cs_reg, o_idx_reg};

    always_comb begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = rd_reg;
        if (state_reg == B_CLEAR) begin
            we = 1'b1; wdata = '0;
        end else if (state_reg == B_MOD) begin
            if (!action_reg && rd_reg != grc_pkg::COUNT_MAX) begin
                we = 1'b1; wdata = rd_reg + 8'd1;
            end else if (action_reg && rd_reg != '0) begin
                we = 1'b1; wdata = rd_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) cnt_mem[waddr] <= wdata;
        rd_reg <= cnt_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= B_CLEAR;
            idx_reg    <= '0;
            ov_reg     <= 1'b0;
            final_reg  <= 1'b0;
            o_last_reg <= 1'b0;
        end else begin
            if (out_load)      ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
            unique case (state_reg)
                B_CLEAR: begin
                    idx_reg <= idx_reg + 10'd1;
                    if (idx_reg == 10'(grc_pkg::NUM_GRANULES - 1)) state_reg <= B_IDLE;
                end
                B_IDLE: if (q_valid) begin
                    action_reg <= q_data.action;
                    idx_reg    <= q_data.gs;
                    cs_reg     <= q_data.cs;
                    left_reg   <= q_data.count;
                    st_reg     <= q_data.reject ? q_data.status : grc_pkg::ST_OK;
                    state_reg  <= (q_data.reject || q_data.count == '0) ? B_OUT : B_READ;
                    final_reg  <= (q_data.reject || q_data.count == '0);
                end
                B_READ: state_reg <= B_WAIT;
                B_WAIT: state_reg <= B_MOD;
                B_MOD: begin
                    if (!action_reg && rd_reg == grc_pkg::COUNT_MAX) begin
                        st_reg <= grc_pkg::ST_FULL; final_reg <= 1'b1; state_reg <= B_OUT;
                    end else if (action_reg && rd_reg == '0) begin
                        st_reg <= grc_pkg::ST_ZERO; final_reg <= 1'b1; state_reg <= B_OUT;
                    end else if (action_reg && rd_reg == 8'd1) begin
                        // freed granule report, then carry on
                        final_reg <= 1'b0;
                        state_reg <= B_OUT;
                    end else begin
                        idx_reg  <= idx_reg + 10'd1;
                        cs_reg   <= ce_w[grc_pkg::LEN_W-1:0];
                        left_reg <= left_reg - 6'd1;
                        if (left_reg == 6'd1) final_reg <= 1'b1;
                        state_reg <= (left_reg == 6'd1) ? B_OUT : B_READ;
                    end
                end
                B_OUT: if (out_load) begin
                    if (final_reg) begin
                        o_kind_reg <= 1'b1;
                        o_last_reg <= 1'b1;
                        o_st_reg   <= st_reg;
                        o_idx_reg <= '0; o_cs_reg <= '0; o_ce_reg <= '0;
                        state_reg <= B_IDLE;
                    end else begin
                        o_kind_reg <= 1'b0;
                        o_last_reg <= 1'b0;
                        o_st_reg   <= grc_pkg::ST_OK;
                        o_idx_reg  <= idx_reg;
                        o_cs_reg   <= cs_reg;
                        o_ce_reg   <= ce_clip;
                        // advance the walk past the freed granule
                        idx_reg  <= idx_reg + 10'd1;
                        cs_reg   <= ce_w[grc_pkg::LEN_W-1:0];
                        left_reg <= left_reg - 6'd1;
                        if (left_reg == 6'd1) final_reg <= 1'b1;
                        state_reg <= (left_reg == 6'd1) ? B_OUT : B_READ;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_report_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (o_st_reg == grc_pkg::ST_OK))
        else $error("freed report with non-zero status");
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == m_tuser)) else $error("last and kind disagree");
    a_no_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_CLEAR) |-> !m_tvalid) else $error("output during clear");
endmodule

/* sv/granule_reference_counter_unit.sv */
// The front registers a request, divides its offset and end by the granule size and
// classifies the walk; a rejected request skips the division. The front takes a new
// request only once the last walk is handed on; the back reads, waits and modifies
// each granule and adds a report per freed one; the two parts overlap through a
// 2-entry queue. Reset: synchronous, active low; a clear pass zeroes the counters,
// during which requests are taken and queued but not walked.
// ----------------------------------------------------------------------------
// granule_reference_counter_unit
// Reference counter per granule with freed-range reporting.
// ----------------------------------------------------------------------------
module granule_reference_counter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // address[31:0], length[52:32]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // granule_index, clear_start, clear_end, status
    output logic        m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [grc_pkg::ADDR_W-1:0] base_reg;
    logic [grc_pkg::LEN_W-1:0]  bytes_reg;
    logic [grc_pkg::GRAN_W-1:0] gran_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            bytes_reg <= 21'd65536;
            gran_reg  <= 13'd64;
        end else if (cfg_we) begin
            case (cfg_index)
                grc_pkg::REG_BASE:  base_reg  <= cfg_data;
                grc_pkg::REG_BYTES: bytes_reg <= cfg_data[grc_pkg::LEN_W-1:0];
                grc_pkg::REG_GRAN:  gran_reg  <= cfg_data[grc_pkg::GRAN_W-1:0];
                default: ;
            endcase
        end
    end

    logic           fq_valid, fq_ready, bq_valid, bq_ready;
    grc_pkg::walk_t fq_data, bq_data;

    grc_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .action(s_tuser), .address(s_tdata[31:0]), .length(s_tdata[52:32]),
        .region_base(base_reg), .region_bytes(bytes_reg), .gran(gran_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    grc_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
    );

    grc_back u_back (
        .aclk, .aresetn,
        .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
        .region_bytes(bytes_reg), .gran(gran_reg),
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
    );
endmodule
